### rtl/mwo_pkg.sv
// shared types, constants and tables for the multi-waveform oscillator
package mwo_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

    // waveform codes
    localparam logic [2:0] MODE_SQUARE   = 3'd0;
    localparam logic [2:0] MODE_SINE     = 3'd1;
    localparam logic [2:0] MODE_SAW      = 3'd2;
    localparam logic [2:0] MODE_TRIANGLE = 3'd3;
    localparam logic [2:0] MODE_NOISE    = 3'd4;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_INC   = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;
    localparam logic [1:0] REG_SEED  = 2'd3;

    localparam logic [2:0]  MODE_RESET = MODE_SINE;
    localparam logic [15:0] SEED_DEFAULT = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] phase_inc;
        logic [15:0] start_phase;
        logic [15:0] lfsr_seed;
    } cfg_t;

    // first quarter of the sine wave, entries 0..64 of the full table
    localparam logic [14:0] QUARTER_SINE [65] = '{
        15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
        15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
        15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
        15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
        15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    // magnitude for the lower 7 bits of the table index, mirrored past the peak
    function automatic logic [14:0] sine_mag(input logic [6:0] half);
        logic [6:0] sel;
        sel = (half <= 7'd64) ? half : (7'd0 - half);
        return QUARTER_SINE[sel];
    endfunction

endpackage

### rtl/multi_waveform_oscillator_top.sv
// top level of the multi-waveform phase-accumulator oscillator
//
// Each request on the s_ channel is one sample tick; s_restart reloads the
// phase accumulator from start_phase and the noise lfsr from lfsr_seed
// (zero seed becomes 0xACE1) before the sample is made. The m_ channel
// returns one result per request: m_sample for the phase before advancing
// and m_phase_after, the accumulator after adding phase_increment.
// Configuration goes through the apb port, registers at 0x0 (mode), 0x4
// (phase increment), 0x8 (start phase), 0xC (lfsr seed); pready is always
// high and writes are meant for when no request is outstanding.
// An accepted request shows up on m_ in the next cycle. Throughput is one
// request per cycle while s_ready is high; the phase and lfsr registers
// close their update loop around the waveform logic and the 16x17 noise
// multiplier. While m_ready is low the result holds and
// s_ready drops only if the output register is full and not being taken.
// Synchronous active-low reset returns the registers to their defaults,
// the phase to zero, the lfsr to 0xACE1 and empties the output register.
module multi_waveform_oscillator_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mwo_pkg::ADDR_W-1:0]   paddr,
    input  logic [mwo_pkg::DATA_W-1:0]   pwdata,
    output logic [mwo_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_restart,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [15:0]           m_sample,
    output logic [15:0]                  m_phase_after
);
    import mwo_pkg::*;

    cfg_t               cfg;
    logic               s_accept;
    logic [15:0]        phase_acc_reg, phase_acc_next;
    logic [15:0]        lfsr_reg, lfsr_next;
    logic [15:0]        phase_cur;
    logic [15:0]        lfsr_load;
    logic [15:0]        lfsr_cur;
    logic [16:0]        phase_sum;
    logic               step_lfsr;
    logic signed [15:0] wave_sample;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_sample_reg;
    logic [15:0]        m_phase_reg;

    mwo_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready   = 1'b1;
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // restart reloads before the sample is formed
    assign phase_cur = s_restart ? cfg.start_phase : phase_acc_reg;
    assign lfsr_load = s_restart ? cfg.lfsr_seed : lfsr_reg;
    assign lfsr_cur  = (lfsr_load == 16'd0) ? SEED_DEFAULT : lfsr_load;

    mwo_wave u_wave (
        .mode   (cfg.mode),
        .phase  (phase_cur),
        .lfsr   (lfsr_cur),
        .sample (wave_sample)
    );

    // lfsr steps only on a phase wrap in noise mode
    assign phase_sum      = {1'b0, phase_cur} + {1'b0, cfg.phase_inc};
    assign step_lfsr      = (cfg.mode == MODE_NOISE) && phase_sum[16];
    assign phase_acc_next = s_accept ? phase_sum[15:0] : phase_acc_reg;
    assign m_valid_next   = s_accept || (m_valid_reg && !m_ready);

    always_comb begin
        lfsr_next = lfsr_reg;
        if (s_accept) begin
            if (step_lfsr) begin
                lfsr_next = {1'b0, lfsr_cur[15:1]} ^ (lfsr_cur[0] ? LFSR_TAPS : 16'd0);
            end else begin
                lfsr_next = lfsr_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= 16'd0;
            lfsr_reg      <= SEED_DEFAULT;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_acc_reg <= phase_acc_next;
            lfsr_reg      <= lfsr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_sample_reg <= wave_sample;
            m_phase_reg  <= phase_sum[15:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample      = m_sample_reg;
    assign m_phase_after = m_phase_reg;

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != 16'd0)
        else $error("noise lfsr reached zero");

    a_accept_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted request produced no result");

    a_phase_matches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_phase_after == phase_acc_reg))
        else $error("reported phase differs from accumulator");

    a_lfsr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_restart && cfg.mode != MODE_NOISE) |=> $stable(lfsr_reg))
        else $error("lfsr moved outside noise mode");

endmodule

### rtl/mwo_regs.sv
// apb configuration registers of the oscillator
module mwo_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mwo_pkg::ADDR_W-1:0]   paddr,
    input  logic [mwo_pkg::DATA_W-1:0]   pwdata,
    output logic [mwo_pkg::DATA_W-1:0]   prdata,
    output mwo_pkg::cfg_t                cfg
);
    import mwo_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode        <= MODE_RESET;
            cfg_reg.phase_inc   <= 16'd0;
            cfg_reg.start_phase <= 16'd0;
            cfg_reg.lfsr_seed   <= SEED_DEFAULT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:  cfg_reg.mode        <= pwdata[2:0];
                REG_INC:   cfg_reg.phase_inc   <= pwdata[15:0];
                REG_START: cfg_reg.start_phase <= pwdata[15:0];
                REG_SEED:  cfg_reg.lfsr_seed   <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:  prdata = {{(DATA_W-3){1'b0}}, cfg_reg.mode};
            REG_INC:   prdata = {{(DATA_W-16){1'b0}}, cfg_reg.phase_inc};
            REG_START: prdata = {{(DATA_W-16){1'b0}}, cfg_reg.start_phase};
            REG_SEED:  prdata = {{(DATA_W-16){1'b0}}, cfg_reg.lfsr_seed};
            default:   prdata = '0;
        endcase
    end

endmodule

### rtl/mwo_wave.sv
// waveform generator: sample for one phase, lfsr value and mode
module mwo_wave (
    input  logic [2:0]   mode,
    input  logic [15:0]  phase,
    input  logic [15:0]  lfsr,
    output logic signed [15:0] sample
);
    import mwo_pkg::*;

    logic [SINE_IDX_W-1:0] sine_idx;
    logic [14:0]           sine_m;
    logic signed [15:0]    sine_s;
    logic [14:0]           tri_q;
    logic [14:0]           tri_t;
    logic signed [15:0]    tri_s;
    logic signed [15:0]    held;
    logic [16:0]           env;
    logic signed [33:0]    prod;

    assign sine_idx = phase[15:8];
    assign sine_m   = sine_mag(sine_idx[6:0]);
    assign sine_s   = sine_idx[7] ? -$signed({1'b0, sine_m}) : $signed({1'b0, sine_m});

    // rising ramp to 32766 then falling, mirrored for the second half
    assign tri_q = phase[14:0];
    assign tri_t = tri_q[14] ? (15'h7FFE - {tri_q[13:0], 1'b0}) : {tri_q[13:0], 1'b0};
    assign tri_s = phase[15] ? -$signed({1'b0, tri_t}) : $signed({1'b0, tri_t});

    // held lfsr value minus 0x8000, scaled by the decaying envelope
    assign held = $signed({~lfsr[15], lfsr[14:0]});
    assign env  = 17'h10000 - {1'b0, phase};
    assign prod = held * $signed({1'b0, env});

    always_comb begin
        unique case (mode)
            MODE_SQUARE:   sample = phase[15] ? -16'sd32767 : 16'sd32767;
            MODE_SINE:     sample = sine_s;
            MODE_SAW:      sample = $signed({~phase[15], phase[14:0]});
            MODE_TRIANGLE: sample = tri_s;
            MODE_NOISE:    sample = prod[31:16];
            default:       sample = 16'sd0;
        endcase
    end

endmodule

### sim/tb.sv
// self-checking testbench for the multi-waveform oscillator top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwo_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PHASES = 16;
    localparam int PHASE_TICKS = 117;

    typedef struct {
        logic signed [15:0] sample;
        logic [15:0]        phase_after;
    } osc_result_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_restart = 1'b0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic signed [15:0]  m_sample;
    logic [15:0]         m_phase_after;

    // oscillator model state and its copy of the registers
    logic [2:0]  cfg_mode  = MODE_RESET;
    logic [15:0] cfg_inc   = 16'h0000;
    logic [15:0] cfg_start = 16'h0000;
    logic [15:0] cfg_seed  = SEED_DEFAULT;
    logic [15:0] osc_phase = 16'h0000;
    logic [15:0] osc_lfsr  = SEED_DEFAULT;

    logic        pending_ticks[$];
    osc_result_t expected_samples[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    multi_waveform_oscillator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_phase_after (m_phase_after)
    );

    always #2 aclk = ~aclk;

    // advance the oscillator by one tick and queue the sample it should produce
    task automatic step_oscillator(input logic restart);
        int          s;
        int          mag;
        int          tri_val;
        logic [6:0]  half;
        logic [14:0] fold;
        longint      held;
        longint      prod;
        logic [16:0] nxt;
        osc_result_t r;
        if (restart) begin
            osc_phase = cfg_start;
            osc_lfsr  = (cfg_seed != 16'h0000) ? cfg_seed : SEED_DEFAULT;
        end
        if (osc_lfsr == 16'h0000)
            osc_lfsr = SEED_DEFAULT;
        case (cfg_mode)
            MODE_SQUARE: s = osc_phase[15] ? -32767 : 32767;
            MODE_SINE: begin
                half = osc_phase[14:8];
                mag  = (half <= 7'd64) ? int'(QUARTER_SINE[half])
                                       : int'(QUARTER_SINE[128 - int'(half)]);
                s    = osc_phase[15] ? -mag : mag;
            end
            MODE_SAW: s = int'(osc_phase) - 32768;
            MODE_TRIANGLE: begin
                fold    = osc_phase[14:0];
                tri_val = (fold < 15'h4000) ? 2 * int'(fold) : 65534 - 2 * int'(fold);
                s       = osc_phase[15] ? -tri_val : tri_val;
            end
            MODE_NOISE: begin
                // held value times decaying envelope, floor of /65536
                held = longint'(osc_lfsr) - 32768;
                prod = held * (65536 - longint'(osc_phase));
                s    = int'(prod >>> 16);
            end
            default: s = 0;
        endcase
        nxt = {1'b0, osc_phase} + {1'b0, cfg_inc};
        if (cfg_mode == MODE_NOISE && nxt[16])
            osc_lfsr = osc_lfsr[0] ? ((osc_lfsr >> 1) ^ LFSR_TAPS) : (osc_lfsr >> 1);
        osc_phase = nxt[15:0];
        r.sample      = s[15:0];
        r.phase_after = osc_phase;
        expected_samples.push_back(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:  cfg_mode  = value[2:0];
            REG_INC:   cfg_inc   = value;
            REG_START: cfg_start = value;
            default:   cfg_seed  = value;
        endcase
    endtask

    task automatic setup_osc(input logic [2:0] mode, input logic [15:0] inc,
                             input logic [15:0] start, input logic [15:0] seed);
        write_reg(REG_MODE, {13'h0, mode});
        write_reg(REG_INC, inc);
        write_reg(REG_START, start);
        write_reg(REG_SEED, seed);
    endtask

    // every request handed over and every sample back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ticks.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                step_oscillator(s_restart);
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_restart <= pending_ticks.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor, with its own long hold-off when asked
    always @(posedge aclk) begin : monitor
        osc_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result: sample %0d phase_after %0h",
                           m_sample, m_phase_after);
                    mismatches++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d", want.sample, m_sample);
                        mismatches++;
                    end
                    if (m_phase_after !== want.phase_after) begin
                        $error("phase_after: expected %0h, got %0h",
                               want.phase_after, m_phase_after);
                        mismatches++;
                    end
                end
            end
            if (hold_reqs != hold_done) begin
                hold_done <= hold_done + 1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [2:0]  mode;
        logic [15:0] inc;
        logic [15:0] start;
        logic [15:0] seed;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: sine at a standing phase
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b0);
        wait_drained();

        // each mode once, extremes of the registers, zero seed in noise,
        // triangle started at its peak
        for (int m = 0; m < 8; m++) begin
            setup_osc(m[2:0], m[0] ? 16'h4000 : 16'hFFFF,
                      (m == 3) ? 16'h4000 : 16'hFFFF,
                      (m == 4) ? 16'h0000 : 16'hFFFF);
            pending_ticks.push_back(1'b1);
            pending_ticks.push_back(1'b0);
            pending_ticks.push_back(1'b0);
            wait_drained();
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode  = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 4));
            case (ph)
                5:       inc = 16'h0000;
                6:       inc = 16'hFFFF;
                7:       inc = 16'h0001;
                default: inc = ph[0] ? 16'($urandom_range(0, 1023))
                                     : 16'($urandom_range(0, 65535));
            endcase
            start = (ph == 3) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            seed  = (ph % 5 == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
            setup_osc(mode, inc, start, seed);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            pending_ticks.push_back(1'b1);
            for (int i = 1; i < PHASE_TICKS; i++)
                pending_ticks.push_back($urandom_range(99) < 6);
            // back up the output while the sender keeps offering
            if (ph == 8)
                hold_reqs <= hold_reqs + 1;
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
